// ===== rtl/core/vhp_pkg.sv =====
// Shared types and constants for the Vorbis header parser.
`timescale 1ns / 1ps

package vhp_pkg;

   // Result status codes; from ST_COUNT on, in order of the checks.
   typedef logic [3:0] status_type;

   localparam status_type ST_OK       = 4'd0;
   localparam status_type ST_LENGTH   = 4'd1;
   localparam status_type ST_COUNT    = 4'd2;
   localparam status_type ST_MAGIC    = 4'd3;
   localparam status_type ST_VERSION  = 4'd4;
   localparam status_type ST_CHANNELS = 4'd5;
   localparam status_type ST_RATE     = 4'd6;
   localparam status_type ST_FRAMING  = 4'd7;
   localparam status_type ST_SETUP    = 4'd8;

   // Field widths of a result beat.
   localparam int unsigned FRAME_SIZE_W = 14;
   typedef logic [FRAME_SIZE_W-1:0] frame_size_type;

   // Stream constants.
   localparam logic [7:0] COUNT_BYTE    = 8'h02;
   localparam logic [7:0] LACE_CONTINUE = 8'hff;
   localparam logic [7:0] SETUP_TYPE    = 8'h05;
   localparam int unsigned IDENT_MIN_LEN = 30;

   // Packet type followed by the word "vorbis".
   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] value;
      case (idx)
         3'd0: value = 8'h01;
         3'd1: value = 8'h76;
         3'd2: value = 8'h6f;
         3'd3: value = 8'h72;
         3'd4: value = 8'h62;
         3'd5: value = 8'h69;
         3'd6: value = 8'h73;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

// ===== rtl/core/vhp_if.sv =====
// Valid/ready channel interfaces for the parser's byte input and result output.
`timescale 1ns / 1ps

interface vhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface vhp_rsp_if;
   logic                     valid;
   logic                     ready;
   vhp_pkg::status_type      status;
   logic [7:0]               channels;
   logic [31:0]              sample_rate;
   logic [31:0]              bitrate_upper;
   logic [31:0]              bitrate_nominal;
   logic [31:0]              bitrate_lower;
   logic [3:0]               short_block_exp;
   logic [3:0]               long_block_exp;
   vhp_pkg::frame_size_type  frame_size;

   modport source (output valid, output status, output channels, output sample_rate,
                   output bitrate_upper, output bitrate_nominal, output bitrate_lower,
                   output short_block_exp, output long_block_exp, output frame_size,
                   input ready);
   modport sink (input valid, input status, input channels, input sample_rate,
                 input bitrate_upper, input bitrate_nominal, input bitrate_lower,
                 input short_block_exp, input long_block_exp, input frame_size,
                 output ready);
endinterface

// ===== rtl/core/vorbis_header_parser_top.sv =====
// Vorbis codec-private header parser: laced lengths, identification checks, result beat.
// Throughput: one input beat per cycle, also while a result beat waits, unless the input register stalls (below).
// The result of a last beat passes through the input register, then the result register.
// The input register stalls only when it holds a last beat and a full result is not taken.
// Synchronous reset returns the parser to the count byte phase with all fields zero.
`timescale 1ns / 1ps

module vorbis_header_parser_top #(
   parameter int unsigned LENGTH_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   vhp_req_if.sink    req_bus,
   vhp_rsp_if.source  rsp_bus
);

   localparam int unsigned LW1 = LENGTH_WIDTH + 1;
   localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

   typedef enum logic [2:0] {
      PH_COUNT,
      PH_LACE0,
      PH_LACE1,
      PH_IDENT,
      PH_COMMENT,
      PH_SETUP0,
      PH_SETUP,
      PH_DRAIN
   } phase_type;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;
   logic       proc;

   // Parser state.
   phase_type                 phase_ff, phase_in;
   logic [LENGTH_WIDTH-1:0]   pos_ff, pos_in;
   logic [LENGTH_WIDTH-1:0]   len1_ff, len1_in;
   logic [LENGTH_WIDTH-1:0]   len2_ff, len2_in;
   vhp_pkg::status_type       err_ff, err_in;
   logic [7:0]                chan_ff, chan_in;
   logic [31:0]               rate_ff, rate_in;
   logic [31:0]               brmax_ff, brmax_in;
   logic [31:0]               brnom_ff, brnom_in;
   logic [31:0]               brmin_ff, brmin_in;
   logic [7:0]                exp_ff, exp_in;

   // Result register.
   logic                      rsp_valid_ff;
   vhp_pkg::status_type       status_ff;
   logic [7:0]                rchan_ff;
   logic [31:0]               rrate_ff, rbrmax_ff, rbrnom_ff, rbrmin_ff;
   logic [3:0]                rshort_ff, rlong_ff;
   vhp_pkg::frame_size_type   rframe_ff;

   // Combinational helpers.
   logic                      code_set;
   vhp_pkg::status_type       code;
   logic [LW1-1:0]            sum1, sum2;
   logic [LENGTH_WIDTH-1:0]   sat1, sat2;
   logic [LW1-1:0]            pos_next_wide;
   vhp_pkg::status_type       status_in;
   logic [3:0]                lo, hi, mexp;
   logic [15:0]               block_one_hot;
   logic [31:0]               lane_word;

   // Stall the stage only when a last beat cannot place its result.
   assign advance = !(in_last_ff && rsp_valid_ff && !rsp_bus.ready);
   assign proc = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Saturating lace sums and position step.
   assign sum1 = LW1'(len1_ff) + LW1'(in_byte_ff);
   assign sum2 = LW1'(len2_ff) + LW1'(in_byte_ff);
   assign sat1 = sum1[LENGTH_WIDTH] ? LEN_MAX : sum1[LENGTH_WIDTH-1:0];
   assign sat2 = sum2[LENGTH_WIDTH] ? LEN_MAX : sum2[LENGTH_WIDTH-1:0];
   assign pos_next_wide = LW1'(pos_ff) + LW1'(1);
   assign lane_word = 32'(in_byte_ff) << {pos_ff[1:0], 3'b000};

   // Next parser state for the beat in the input register.
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      len1_in  = len1_ff;
      len2_in  = len2_ff;
      chan_in  = chan_ff;
      rate_in  = rate_ff;
      brmax_in = brmax_ff;
      brnom_in = brnom_ff;
      brmin_in = brmin_ff;
      exp_in   = exp_ff;
      code_set = 1'b0;
      code     = vhp_pkg::ST_OK;
      case (phase_ff)
         PH_COUNT: begin
            pos_in = LENGTH_WIDTH'(1);
            if (in_byte_ff != vhp_pkg::COUNT_BYTE) begin
               code_set = 1'b1;
               code     = vhp_pkg::ST_COUNT;
               phase_in = PH_DRAIN;
            end else begin
               phase_in = PH_LACE0;
            end
         end
         PH_LACE0: begin
            len1_in = sat1;
            if (in_byte_ff != vhp_pkg::LACE_CONTINUE) begin
               phase_in = PH_LACE1;
            end
         end
         PH_LACE1: begin
            len2_in = sat2;
            if (in_byte_ff != vhp_pkg::LACE_CONTINUE) begin
               if (len1_ff < LENGTH_WIDTH'(vhp_pkg::IDENT_MIN_LEN) ||
                   sat2 <= LENGTH_WIDTH'(1)) begin
                  code_set = 1'b1;
                  code     = vhp_pkg::ST_LENGTH;
                  pos_in   = LEN_MAX;
                  phase_in = PH_DRAIN;
               end else begin
                  pos_in   = '0;
                  phase_in = PH_IDENT;
               end
            end
         end
         PH_IDENT: begin
            // Field checks and captures by offset within the identification header.
            if (pos_ff < LENGTH_WIDTH'(7)) begin
               if (in_byte_ff != vhp_pkg::magic_byte(pos_ff[2:0])) begin
                  code_set = 1'b1;
                  code     = vhp_pkg::ST_MAGIC;
               end
            end else if (pos_ff < LENGTH_WIDTH'(11)) begin
               if (in_byte_ff != 8'h00) begin
                  code_set = 1'b1;
                  code     = vhp_pkg::ST_VERSION;
               end
            end else if (pos_ff == LENGTH_WIDTH'(11)) begin
               chan_in = in_byte_ff;
               if (in_byte_ff == 8'h00) begin
                  code_set = 1'b1;
                  code     = vhp_pkg::ST_CHANNELS;
               end
            end else if (pos_ff < LENGTH_WIDTH'(16)) begin
               rate_in = rate_ff | lane_word;
               if (pos_ff == LENGTH_WIDTH'(15) && (rate_ff | lane_word) == 32'h0) begin
                  code_set = 1'b1;
                  code     = vhp_pkg::ST_RATE;
               end
            end else if (pos_ff < LENGTH_WIDTH'(20)) begin
               brmax_in = brmax_ff | lane_word;
            end else if (pos_ff < LENGTH_WIDTH'(24)) begin
               brnom_in = brnom_ff | lane_word;
            end else if (pos_ff < LENGTH_WIDTH'(28)) begin
               brmin_in = brmin_ff | lane_word;
            end else if (pos_ff == LENGTH_WIDTH'(28)) begin
               exp_in = in_byte_ff;
            end else if (pos_ff == LENGTH_WIDTH'(29)) begin
               if (!in_byte_ff[0]) begin
                  code_set = 1'b1;
                  code     = vhp_pkg::ST_FRAMING;
               end
            end
            if (pos_next_wide >= LW1'(len1_ff)) begin
               pos_in   = '0;
               phase_in = PH_COMMENT;
            end else begin
               pos_in = pos_next_wide[LENGTH_WIDTH-1:0];
            end
         end
         PH_COMMENT: begin
            if (pos_next_wide >= LW1'(len2_ff)) begin
               pos_in   = '0;
               phase_in = PH_SETUP0;
            end else begin
               pos_in = pos_next_wide[LENGTH_WIDTH-1:0];
            end
         end
         PH_SETUP0: begin
            if (in_byte_ff != vhp_pkg::SETUP_TYPE) begin
               code_set = 1'b1;
               code     = vhp_pkg::ST_SETUP;
            end
            phase_in = PH_SETUP;
         end
         PH_SETUP: begin
            phase_in = PH_SETUP;
         end
         PH_DRAIN: begin
            pos_in = (pos_ff == LEN_MAX) ? pos_ff : pos_next_wide[LENGTH_WIDTH-1:0];
         end
         default: begin
            phase_in = PH_DRAIN;
         end
      endcase
      // Only the first error is kept.
      err_in = (err_ff == vhp_pkg::ST_OK && code_set) ? code : err_ff;
   end

   // Status of a last beat.
   always_comb begin
      if (phase_ff == PH_DRAIN || phase_in == PH_DRAIN) begin
         if (err_in == vhp_pkg::ST_COUNT && pos_in <= LENGTH_WIDTH'(3)) begin
            status_in = vhp_pkg::ST_LENGTH;
         end else begin
            status_in = err_in;
         end
      end else if (phase_ff == PH_SETUP) begin
         status_in = err_in;
      end else begin
         status_in = vhp_pkg::ST_LENGTH;
      end
   end

   // Block size exponents and frame size from the smaller one.
   assign lo = exp_in[3:0];
   assign hi = exp_in[7:4];
   assign mexp = (lo < hi) ? lo : hi;
   assign block_one_hot = 16'(1) << mexp;

   // Input register and parser state; a processed last beat restarts the parser.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_COUNT;
         pos_ff      <= '0;
         len1_ff     <= '0;
         len2_ff     <= '0;
         err_ff      <= vhp_pkg::ST_OK;
         chan_ff     <= '0;
         rate_ff     <= '0;
         brmax_ff    <= '0;
         brnom_ff    <= '0;
         brmin_ff    <= '0;
         exp_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (proc && in_last_ff) begin
            phase_ff <= PH_COUNT;
            pos_ff   <= '0;
            len1_ff  <= '0;
            len2_ff  <= '0;
            err_ff   <= vhp_pkg::ST_OK;
            chan_ff  <= '0;
            rate_ff  <= '0;
            brmax_ff <= '0;
            brnom_ff <= '0;
            brmin_ff <= '0;
            exp_ff   <= '0;
         end else if (proc) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            len1_ff  <= len1_in;
            len2_ff  <= len2_in;
            err_ff   <= err_in;
            chan_ff  <= chan_in;
            rate_ff  <= rate_in;
            brmax_ff <= brmax_in;
            brnom_ff <= brnom_in;
            brmin_ff <= brmin_in;
            exp_ff   <= exp_in;
         end
      end
   end

   // Input payload capture.
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.last_byte;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && in_last_ff) begin
         status_ff <= status_in;
         rchan_ff  <= chan_in;
         rrate_ff  <= rate_in;
         rbrmax_ff <= brmax_in;
         rbrnom_ff <= brnom_in;
         rbrmin_ff <= brmin_in;
         rshort_ff <= lo;
         rlong_ff  <= hi;
         rframe_ff <= block_one_hot[vhp_pkg::FRAME_SIZE_W+1:2];
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = status_ff;
   assign rsp_bus.channels        = rchan_ff;
   assign rsp_bus.sample_rate     = rrate_ff;
   assign rsp_bus.bitrate_upper   = rbrmax_ff;
   assign rsp_bus.bitrate_nominal = rbrnom_ff;
   assign rsp_bus.bitrate_lower   = rbrmin_ff;
   assign rsp_bus.short_block_exp = rshort_ff;
   assign rsp_bus.long_block_exp  = rlong_ff;
   assign rsp_bus.frame_size      = rframe_ff;

   // A processed last beat always restarts the parser at the count byte.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      proc && in_last_ff |=> phase_ff == PH_COUNT && err_ff == vhp_pkg::ST_OK)
      else $error("parser did not restart after a last beat");

   // The input stage stalls only behind a waiting result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> rsp_valid_ff && in_last_ff)
      else $error("input stage stalled without a waiting result");

   // A good result always carries a nonzero channel count and rate.
   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == vhp_pkg::ST_OK |-> rchan_ff != 8'h00 && rrate_ff != 32'h0)
      else $error("good status with zero channels or rate");

   // Status codes stay within the defined set.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> status_ff <= vhp_pkg::ST_SETUP)
      else $error("result status out of range");

endmodule
